// ===== rtl/sfp_pkg.sv =====
`default_nettype none

package sfp_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'h23;
  localparam logic [7:0] SYNC_SECOND = 8'h3E;
  localparam logic [7:0] ID_FIRST    = 8'h06;
  localparam logic [7:0] ID_SECOND   = 8'h21;

  localparam logic [7:0] LENGTH_RESET = 8'd81;

  localparam logic [2:0] EV_HUNT     = 3'd0;
  localparam logic [2:0] EV_PROGRESS = 3'd1;
  localparam logic [2:0] EV_PAYLOAD  = 3'd2;
  localparam logic [2:0] EV_GOOD     = 3'd3;
  localparam logic [2:0] EV_ERROR    = 3'd4;

  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_SYNC = 3'd1;
  localparam logic [2:0] ERR_ID   = 3'd2;
  localparam logic [2:0] ERR_LEN  = 3'd3;
  localparam logic [2:0] ERR_CHK  = 3'd4;

  typedef struct packed {
    logic [2:0] event_res;
    logic [2:0] error_kind;
    logic [7:0] data_byte;
    logic [7:0] payload_index;
    logic       last_payload;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/sfp_in_stage.sv =====
`default_nettype none

module sfp_in_stage
  import sfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  input  wire logic       advance,
  output logic            fire,
  output logic [7:0]      held_byte
);

  logic held_valid;

  assign in_stall = held_valid && !advance;
  assign fire     = held_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_byte <= rx_byte;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sfp_core.sv =====
`default_nettype none

module sfp_core
  import sfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire logic [7:0] held_byte,
  input  wire logic [7:0] expected_length,
  output result_t         result
);

  typedef enum logic [4:0] {
    PH_HUNT = 5'b00001,
    PH_ID   = 5'b00010,
    PH_LEN  = 5'b00100,
    PH_PAY  = 5'b01000,
    PH_CHK  = 5'b10000
  } phase_t;

  phase_t     phase, phase_next;
  logic       second_byte_flag, second_byte_flag_next;
  logic [7:0] length_low_byte, length_low_byte_next;
  logic [7:0] payload_count, payload_count_next;
  logic [7:0] sum_a, sum_a_next;
  logic [7:0] sum_b, sum_b_next;
  logic [7:0] acc_a;
  logic [7:0] acc_b;
  logic [8:0] count_plus;

  assign acc_a      = sum_a + held_byte;
  assign acc_b      = sum_b + acc_a;
  assign count_plus = {1'b0, payload_count} + 9'd1;

  always_comb begin
    phase_next            = phase;
    second_byte_flag_next = second_byte_flag;
    length_low_byte_next  = length_low_byte;
    payload_count_next    = payload_count;
    sum_a_next            = sum_a;
    sum_b_next            = sum_b;
    result                = '0;
    unique case (phase)
      PH_HUNT: begin
        sum_a_next = '0;
        sum_b_next = '0;
        if (!second_byte_flag) begin
          if (held_byte == SYNC_FIRST) begin
            second_byte_flag_next = 1'b1;
            result.event_res      = EV_PROGRESS;
          end
        end else if (held_byte == SYNC_SECOND) begin
          second_byte_flag_next = 1'b0;
          phase_next            = PH_ID;
          result.event_res      = EV_PROGRESS;
        end else begin
          result.event_res      = EV_ERROR;
          result.error_kind     = ERR_SYNC;
          second_byte_flag_next = 1'b0;
          payload_count_next    = '0;
        end
      end
      PH_ID: begin
        sum_a_next = acc_a;
        sum_b_next = acc_b;
        if (held_byte == (second_byte_flag ? ID_SECOND : ID_FIRST)) begin
          result.event_res      = EV_PROGRESS;
          second_byte_flag_next = !second_byte_flag;
          if (second_byte_flag) begin
            phase_next = PH_LEN;
          end
        end else begin
          result.event_res      = EV_ERROR;
          result.error_kind     = ERR_ID;
          phase_next            = PH_HUNT;
          second_byte_flag_next = 1'b0;
          payload_count_next    = '0;
          sum_a_next            = '0;
          sum_b_next            = '0;
        end
      end
      PH_LEN: begin
        sum_a_next = acc_a;
        sum_b_next = acc_b;
        if (!second_byte_flag) begin
          length_low_byte_next  = held_byte;
          second_byte_flag_next = 1'b1;
          result.event_res      = EV_PROGRESS;
        end else if (held_byte == 8'd0 && length_low_byte == expected_length) begin
          second_byte_flag_next = 1'b0;
          payload_count_next    = '0;
          phase_next            = (expected_length == 8'd0) ? PH_CHK : PH_PAY;
          result.event_res      = EV_PROGRESS;
        end else begin
          result.event_res      = EV_ERROR;
          result.error_kind     = ERR_LEN;
          phase_next            = PH_HUNT;
          second_byte_flag_next = 1'b0;
          payload_count_next    = '0;
          sum_a_next            = '0;
          sum_b_next            = '0;
        end
      end
      PH_PAY: begin
        sum_a_next           = acc_a;
        sum_b_next           = acc_b;
        result.event_res     = EV_PAYLOAD;
        result.data_byte     = held_byte;
        result.payload_index = payload_count;
        if (count_plus >= {1'b0, expected_length}) begin
          result.last_payload   = 1'b1;
          payload_count_next    = '0;
          second_byte_flag_next = 1'b0;
          phase_next            = PH_CHK;
        end else begin
          payload_count_next = count_plus[7:0];
        end
      end
      PH_CHK: begin
        if (held_byte == (second_byte_flag ? sum_b : sum_a)) begin
          if (second_byte_flag) begin
            result.event_res      = EV_GOOD;
            phase_next            = PH_HUNT;
            second_byte_flag_next = 1'b0;
            payload_count_next    = '0;
            sum_a_next            = '0;
            sum_b_next            = '0;
          end else begin
            second_byte_flag_next = 1'b1;
            result.event_res      = EV_PROGRESS;
          end
        end else begin
          result.event_res      = EV_ERROR;
          result.error_kind     = ERR_CHK;
          phase_next            = PH_HUNT;
          second_byte_flag_next = 1'b0;
          payload_count_next    = '0;
          sum_a_next            = '0;
          sum_b_next            = '0;
        end
      end
      default: begin
        phase_next            = PH_HUNT;
        second_byte_flag_next = 1'b0;
        payload_count_next    = '0;
        sum_a_next            = '0;
        sum_b_next            = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HUNT;
      second_byte_flag <= 1'b0;
      length_low_byte  <= '0;
      payload_count    <= '0;
      sum_a            <= '0;
      sum_b            <= '0;
    end else if (fire) begin
      phase            <= phase_next;
      second_byte_flag <= second_byte_flag_next;
      length_low_byte  <= length_low_byte_next;
      payload_count    <= payload_count_next;
      sum_a            <= sum_a_next;
      sum_b            <= sum_b_next;
    end
  end

`ifndef SYNTH
  a_err_on_error_event: assert property (@(posedge clk) disable iff (rst)
    fire |-> ((result.error_kind != ERR_NONE) == (result.event_res == EV_ERROR)))
    else $error("error kind disagrees with event");

  a_error_returns_hunt: assert property (@(posedge clk) disable iff (rst)
    (fire && result.event_res == EV_ERROR) |=>
      (phase == PH_HUNT && sum_a == 8'd0 && sum_b == 8'd0))
    else $error("error did not return to hunting");

  a_last_enters_check: assert property (@(posedge clk) disable iff (rst)
    (fire && result.last_payload) |=> (phase == PH_CHK && !second_byte_flag))
    else $error("last payload byte did not enter checksum phase");
`endif

endmodule

`default_nettype wire

// ===== rtl/sfp_out_stage.sv =====
`default_nettype none

module sfp_out_stage
  import sfp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  fire,
  input  wire logic  held_valid,
  input  result_t    result,
  output logic       advance,
  output logic       out_valid,
  input  wire logic  out_stall,
  output result_t    out_result
);

  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_result <= result;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sync_frame_parser_fletcher8.sv =====
// Frame parser for a byte stream: hunts for sync 0x23 0x3E, checks ID 0x06 0x21 and a
// little-endian length against expected_length, passes payload bytes out with their index,
// then checks two Fletcher-style bytes; one result per received byte. A byte is taken every
// cycle unless in_stall is high; each goes through an input register, then the parser state
// update into a result register that presents its result. Stalls on the output back
// up through both registers; expected_length is to be written only while the parser is idle,
// which the block itself does not enforce, and cfg_ready is always high.
`default_nettype none

module sync_frame_parser_fletcher8
  import sfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      event_res,
  output logic [2:0]      error_kind,
  output logic [7:0]      data_byte,
  output logic [7:0]      payload_index,
  output logic            last_payload
);

  logic       advance;
  logic       fire;
  logic [7:0] held_byte;
  logic [7:0] expected_length;
  result_t    result;
  result_t    out_result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length <= LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      expected_length <= cfg_data;
    end
  end

  sfp_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .advance   (advance),
    .fire      (fire),
    .held_byte (held_byte)
  );

  sfp_core u_core (
    .clk             (clk),
    .rst             (rst),
    .fire            (fire),
    .held_byte       (held_byte),
    .expected_length (expected_length),
    .result          (result)
  );

  sfp_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .held_valid (fire),
    .result     (result),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign event_res     = out_result.event_res;
  assign error_kind    = out_result.error_kind;
  assign data_byte     = out_result.data_byte;
  assign payload_index = out_result.payload_index;
  assign last_payload  = out_result.last_payload;

endmodule

`default_nettype wire
